// ----- design/wheel_speed_from_capture_period_assert.svh -----
// Assertion macros for the design file wheel_speed_from_capture_period.sv.
// Define ASSERT_OFF to compile the checks out.
`ifndef WHEEL_SPEED_FROM_CAPTURE_PERIOD_ASSERT_SVH
`define WHEEL_SPEED_FROM_CAPTURE_PERIOD_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication: ante |-> cons
`define WSPD_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication: ante |=> cons
`define WSPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`else

`define WSPD_ASSERT_IMPL(label, clk, rst, ante, cons)
`define WSPD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- design/wspd_pkg.sv -----
`timescale 1ns / 1ps

package wspd_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned RES_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CNT_W     = $clog2(DATA_W);

  // Register indexes
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_TIMEOUT   = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_SPEED_NUM = cfg_idx_t'(1);
  localparam cfg_idx_t CFG_RATE_NUM  = cfg_idx_t'(2);

  // Register reset values
  localparam logic [DATA_W-1:0] TIMEOUT_RST   = 32'd40000000;
  localparam logic [DATA_W-1:0] SPEED_NUM_RST = 32'd2497500000;
  localparam logic [DATA_W-1:0] RATE_NUM_RST  = 32'd416666667;

  localparam logic [RES_W-1:0] SAT16 = '1;

  // Division slots, in the order the sequencer runs them
  typedef logic [2:0] op_t;
  localparam op_t OP_FL   = 3'd0;
  localparam op_t OP_FR   = 3'd1;
  localparam op_t OP_RL   = 3'd2;
  localparam op_t OP_RR   = 3'd3;
  localparam op_t OP_RATE = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  typedef struct packed {
    logic [DATA_W-1:0] period_front_left;
    logic [DATA_W-1:0] period_front_right;
    logic [DATA_W-1:0] period_rear_left;
    logic [DATA_W-1:0] period_rear_right;
    logic [DATA_W-1:0] since_edge_front_left;
    logic [DATA_W-1:0] since_edge_front_right;
    logic [DATA_W-1:0] since_edge_rear_left;
    logic [DATA_W-1:0] since_edge_rear_right;
    logic              overflow_front_left;
    logic              overflow_front_right;
    logic              overflow_rear_left;
    logic              overflow_rear_right;
  } item_t;

  typedef struct packed {
    logic [RES_W-1:0] speed_front_left;
    logic [RES_W-1:0] speed_front_right;
    logic [RES_W-1:0] speed_rear_left;
    logic [RES_W-1:0] speed_rear_right;
    logic [RES_W-1:0] speed_front_mean;
    logic [RES_W-1:0] speed_rear_mean;
    logic [RES_W-1:0] speed_overall;
    logic [RES_W-1:0] rear_left_turn_rate;
  } result_t;

endpackage

// ----- design/wheel_speed_from_capture_period.sv -----
`timescale 1ns / 1ps
//
//  Channel   Signals                              Direction  Transaction when
//  -------   -----------------------------------  ---------  ---------------------------
//  item      item_valid, item_stall, item          in         item_valid && !item_stall
//  result    result_valid, result_stall, result    out        result_valid && !result_stall
//  cfg       cfg_valid, cfg_ready, cfg_index,      in         cfg_valid && cfg_ready
//            cfg_data
//
//  Sequence: an item is taken only while idle (item_stall otherwise), then
//  five 32-step restoring divisions (4 wheel speeds + rear-left turn rate) run on
//  a single shared subtract/compare unit at one quotient bit per cycle, and
//  the finish state forms the means and loads the result register.
//  Reset: rst is synchronous, active high; it restores the register defaults,
//  clears the held turn rate and empties the result register.
//  Stalls: a finished result sits in the result register while the next item
//  is accepted and divided; only a second finished result waits for it.
//  cfg_ready is always high; the user must make writes only while the block is idle (not enforced).
//
`include "wheel_speed_from_capture_period_assert.svh"

module wheel_speed_from_capture_period (
  input  logic                          clk,
  input  logic                          rst,
  // item channel
  input  logic                          item_valid,
  output logic                          item_stall,
  input  wspd_pkg::item_t               item,
  // result channel
  output logic                          result_valid,
  input  logic                          result_stall,
  output wspd_pkg::result_t             result,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  wspd_pkg::cfg_idx_t            cfg_index,
  input  logic [wspd_pkg::DATA_W-1:0]   cfg_data
);

  localparam int unsigned DW = wspd_pkg::DATA_W;
  localparam int unsigned RW = wspd_pkg::RES_W;
  localparam int unsigned CW = wspd_pkg::CNT_W;
  localparam logic [CW-1:0] CNT_LAST = CW'(DW - 1);

  // Configuration registers
  logic [DW-1:0] timeout_ticks;
  logic [DW-1:0] speed_numerator;
  logic [DW-1:0] rate_numerator;

  // Sequencer
  wspd_pkg::state_t state;
  wspd_pkg::op_t    op;
  logic [CW-1:0]    cnt;

  // Latched item: periods and per-wheel running flags
  logic [DW-1:0] period [4];
  logic [3:0]    running;

  // Shared divider: remainder and dividend/quotient shift register
  logic [DW-1:0] rem;
  logic [DW-1:0] quo;

  // Per-item results and the held turn rate
  logic [RW-1:0] spd [4];
  logic [RW-1:0] held_turn_rate;

  // Divider datapath
  logic [DW-1:0] den;
  logic [DW:0]   shifted;
  logic [DW:0]   trial;
  logic [DW-1:0] rem_next;
  logic [DW-1:0] quo_next;
  logic [RW-1:0] quo_sat;

  // Means
  logic [RW-1:0] front_mean;
  logic [RW-1:0] rear_mean;
  logic [RW-1:0] overall_mean;
  logic [RW:0]   front_sum;
  logic [RW:0]   rear_sum;
  logic [RW:0]   overall_sum;

  logic [3:0] running_in;
  logic       item_accept;
  logic       result_free;

  assign cfg_ready   = 1'b1;
  assign item_stall  = (state != wspd_pkg::S_IDLE);
  assign item_accept = item_valid && !item_stall;
  // result register can be (re)loaded this cycle
  assign result_free = !result_valid || !result_stall;

  // Stopped when since-edge count is above timeout or the counter overflowed
  always_comb begin
    running_in[0] = !(item.since_edge_front_left  > timeout_ticks || item.overflow_front_left);
    running_in[1] = !(item.since_edge_front_right > timeout_ticks || item.overflow_front_right);
    running_in[2] = !(item.since_edge_rear_left   > timeout_ticks || item.overflow_rear_left);
    running_in[3] = !(item.since_edge_rear_right  > timeout_ticks || item.overflow_rear_right);
  end

  // Divisor for the current slot; the turn rate divides by the rear-left period
  always_comb begin
    case (op)
      wspd_pkg::OP_FL: den = period[0];
      wspd_pkg::OP_FR: den = period[1];
      wspd_pkg::OP_RL: den = period[2];
      wspd_pkg::OP_RR: den = period[3];
      default:         den = period[2];
    endcase
  end

  // One restoring step: shift in the next dividend bit, try the subtract.
  // A zero divisor always succeeds, giving an all-ones quotient that
  // saturates to 65535 as required.
  always_comb begin
    shifted  = {rem, quo[DW-1]};
    trial    = shifted - {1'b0, den};
    if (!trial[DW]) begin
      rem_next = trial[DW-1:0];
      quo_next = {quo[DW-2:0], 1'b1};
    end else begin
      rem_next = shifted[DW-1:0];
      quo_next = {quo[DW-2:0], 1'b0};
    end
    quo_sat = (quo_next[DW-1:RW] != '0) ? wspd_pkg::SAT16 : quo_next[RW-1:0];
  end

  // Truncated means
  always_comb begin
    front_sum    = {1'b0, spd[0]} + {1'b0, spd[1]};
    rear_sum     = {1'b0, spd[2]} + {1'b0, spd[3]};
    front_mean   = front_sum[RW:1];
    rear_mean    = rear_sum[RW:1];
    overall_sum  = {1'b0, front_mean} + {1'b0, rear_mean};
    overall_mean = overall_sum[RW:1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= wspd_pkg::S_IDLE;
      op              <= wspd_pkg::OP_FL;
      cnt             <= '0;
      result_valid    <= 1'b0;
      held_turn_rate  <= '0;
      timeout_ticks   <= wspd_pkg::TIMEOUT_RST;
      speed_numerator <= wspd_pkg::SPEED_NUM_RST;
      rate_numerator  <= wspd_pkg::RATE_NUM_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          wspd_pkg::CFG_TIMEOUT:   timeout_ticks   <= cfg_data;
          wspd_pkg::CFG_SPEED_NUM: speed_numerator <= cfg_data;
          wspd_pkg::CFG_RATE_NUM:  rate_numerator  <= cfg_data;
          default: ;  // unknown index: write dropped
        endcase
      end

      // the finish state reloads the register itself
      if (result_valid && !result_stall && (state != wspd_pkg::S_DONE)) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        wspd_pkg::S_IDLE: begin
          if (item_accept) begin
            period[0] <= item.period_front_left;
            period[1] <= item.period_front_right;
            period[2] <= item.period_rear_left;
            period[3] <= item.period_rear_right;
            running   <= running_in;
            quo       <= speed_numerator;
            rem       <= '0;
            cnt       <= '0;
            op        <= wspd_pkg::OP_FL;
            state     <= wspd_pkg::S_DIV;
          end
        end

        wspd_pkg::S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            rem <= '0;
            if (op == wspd_pkg::OP_RATE) begin
              // turn rate only updates while the rear-left wheel runs
              if (running[2]) begin
                held_turn_rate <= quo_sat;
              end
              state <= wspd_pkg::S_DONE;
            end else begin
              spd[op[1:0]] <= running[op[1:0]] ? quo_sat : '0;
              op           <= op + 1'b1;
              quo          <= (op == wspd_pkg::OP_RR) ? rate_numerator : speed_numerator;
            end
          end else begin
            rem <= rem_next;
            quo <= quo_next;
          end
        end

        wspd_pkg::S_DONE: begin
          if (result_free) begin
            result.speed_front_left    <= spd[0];
            result.speed_front_right   <= spd[1];
            result.speed_rear_left     <= spd[2];
            result.speed_rear_right    <= spd[3];
            result.speed_front_mean    <= front_mean;
            result.speed_rear_mean     <= rear_mean;
            result.speed_overall       <= overall_mean;
            result.rear_left_turn_rate <= held_turn_rate;
            result_valid               <= 1'b1;
            state                      <= wspd_pkg::S_IDLE;
          end
        end

        default: state <= wspd_pkg::S_IDLE;
      endcase
    end
  end

  // An accepted item always starts the divider on the first slot
  `WSPD_ASSERT_NEXT(a_accept_starts_div, clk, rst, item_accept,
    (state == wspd_pkg::S_DIV) && (op == wspd_pkg::OP_FL) && (cnt == '0))
  // Slot index never runs past the turn-rate division
  `WSPD_ASSERT_IMPL(a_op_range, clk, rst, 1'b1, op <= wspd_pkg::OP_RATE)
  // A new result only appears out of the finish state
  `WSPD_ASSERT_IMPL(a_result_from_done, clk, rst, $rose(result_valid), $past(state) == wspd_pkg::S_DONE)
  // Held turn rate changes only at the end of the turn-rate division
  `WSPD_ASSERT_IMPL(a_held_update, clk, rst, !$past(rst) && !$stable(held_turn_rate),
    $past(state == wspd_pkg::S_DIV && op == wspd_pkg::OP_RATE && cnt == CNT_LAST))

endmodule
